>>> rtl/core/sgpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgpf_pkg
// shared types, constants and helper functions of the softened gravity
// pair force pipeline
// ----------------------------------------------------------------------------
package sgpf_pkg;

	// fractional bits of the fixed point input formats; the newton chain uses q2.30
	localparam int FRAC_BITS    = 16;
	// newton steps of the reciprocal square root
	localparam int NEWTON_STEPS = 6;
	// width of the signed binary exponent carried with the mantissa chain
	localparam int EXW          = 10;
	// fixed exponent offset of the final scaling
	localparam int SH_BIAS      = 3 * FRAC_BITS + 30;

	localparam logic [31:0] GRAV_RESET = 32'd65536;
	localparam logic [31:0] SOFT_RESET = 32'd655;
	// 1.5 and 3.0 in q2.30
	localparam logic [31:0] SEED_Q30   = 32'h6000_0000;
	localparam logic [33:0] THREE_Q30  = 34'h0_C000_0000;

	typedef enum logic {
		CFG_GRAV = 1'b0,
		CFG_SOFT = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] disp_x;
		logic signed [31:0] disp_y;
		logic signed [31:0] disp_z;
		logic [47:0]        mass_a;
		logic [47:0]        mass_b;
	} pair_t;

	typedef struct packed {
		logic signed [63:0] force_x;
		logic signed [63:0] force_y;
		logic signed [63:0] force_z;
		logic               overflow_flag;
	} force_t;

	// per item data that travels alongside the reciprocal square root
	typedef struct packed {
		logic [2:0]             neg;
		logic [2:0]             mzero;
		logic [2:0][31:0]       magm;
		logic [2:0][EXW-1:0]    magx;
		logic [31:0]            basem;
		logic signed [EXW-1:0]  bex;
		logic signed [7:0]      k3;
		logic                   zden;
		logic                   zfac;
	} side_t;

	// position of the top set bit
	function automatic logic [5:0] lead64(input logic [63:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) p = 6'(i);
		end
		return p;
	endfunction

	// move the bit at position p to bit 31, truncating
	function automatic logic [31:0] norm_shift(input logic [63:0] v, input logic [5:0] p);
		logic [63:0] s;
		if (p >= 6'd31) s = v >> (p - 6'd31);
		else s = v << (6'd31 - p);
		return s[31:0];
	endfunction

	// exponent gained by normalizing from top bit p
	function automatic logic signed [EXW-1:0] pos_exp(input logic [5:0] p);
		return $signed(EXW'(p)) - $signed(EXW'(31));
	endfunction

	// renormalize a product of two normalized mantissas
	function automatic logic [31:0] renorm_mant(input logic [63:0] p);
		return p[63] ? p[63:32] : p[62:31];
	endfunction

	function automatic logic signed [EXW-1:0] renorm_exp(input logic [63:0] p);
		return p[63] ? $signed(EXW'(32)) : $signed(EXW'(31));
	endfunction

endpackage

>>> rtl/core/sgpf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgpf_front
// magnitudes, squared distance, normalization of d2 and of the factors,
// mass product and newton seed; seven stages
// ----------------------------------------------------------------------------
module sgpf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  sgpf_pkg::pair_t      pair,
	input  logic [31:0]          grav,
	input  logic [31:0]          eps_sq,
	output logic                 valid,
	output logic [31:0]          m,
	output logic [31:0]          seed,
	output sgpf_pkg::side_t      side
);

	logic [2:0][31:0] disp;
	logic [2:0][31:0] mag_c;
	logic [2:0]       neg_c;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic [2:0][31:0] mag_s1, mag_s2;
	logic [2:0]       neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [47:0]      ma_s1, mb_s1, ma_s2, mb_s2;
	logic [2:0][63:0] sq_s2;
	logic [2:0][5:0]  pm_s2;
	logic [5:0]       pma_s2, pmb_s2, pg_s2;
	logic [2:0]       mzero_s2, mzero_s3, mzero_s4, mzero_s5, mzero_s6;
	logic             zfac_s2, zfac_s3, zfac_s4, zfac_s5, zfac_s6;
	logic [63:0]      sa_s3, sb_s3;
	logic [2:0][31:0] magm_s3, magm_s4, magm_s5, magm_s6;
	logic [2:0][sgpf_pkg::EXW-1:0] magx_s3, magx_s4, magx_s5, magx_s6;
	logic [31:0]      gm_s3, mam_s3, mbm_s3, mbm_s4, mbm_s5;
	logic signed [sgpf_pkg::EXW-1:0] bex_s3, bex_s4, bex_s5, bex_s6;
	logic [63:0]      d2_s4, d2_s5;
	logic [63:0]      p1_s4, p2_s6;
	logic [5:0]       pd_s5;
	logic             zden_s5, zden_s6;
	logic [31:0]      m1_s5;
	logic [31:0]      m_s6, m_s7, y_s7;
	logic signed [7:0] k3_s6;
	sgpf_pkg::side_t  side_s7;

	// two's complement magnitudes of the displacement
	assign disp = {pair.disp_z, pair.disp_y, pair.disp_x};
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			neg_c[c] = disp[c][31];
			mag_c[c] = neg_c[c] ? (32'd0 - disp[c]) : disp[c];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: capture
			mag_s1 <= mag_c;
			neg_s1 <= neg_c;
			ma_s1  <= pair.mass_a;
			mb_s1  <= pair.mass_b;

			// s2: squares and top bit positions
			for (int c = 0; c < 3; c++) begin
				sq_s2[c]    <= 64'(mag_s1[c]) * 64'(mag_s1[c]);
				pm_s2[c]    <= sgpf_pkg::lead64({32'd0, mag_s1[c]});
				mzero_s2[c] <= (mag_s1[c] == 32'd0);
			end
			pma_s2  <= sgpf_pkg::lead64({16'd0, ma_s1});
			pmb_s2  <= sgpf_pkg::lead64({16'd0, mb_s1});
			pg_s2   <= sgpf_pkg::lead64({32'd0, grav});
			zfac_s2 <= (grav == 32'd0) || (ma_s1 == 48'd0) || (mb_s1 == 48'd0);
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			ma_s2   <= ma_s1;
			mb_s2   <= mb_s1;

			// s3: partial sums and factor mantissas
			sa_s3 <= sq_s2[0] + sq_s2[1];
			sb_s3 <= sq_s2[2] + (64'(eps_sq) << sgpf_pkg::FRAC_BITS);
			for (int c = 0; c < 3; c++) begin
				magm_s3[c] <= sgpf_pkg::norm_shift({32'd0, mag_s2[c]}, pm_s2[c]);
				magx_s3[c] <= sgpf_pkg::pos_exp(pm_s2[c]);
			end
			gm_s3    <= sgpf_pkg::norm_shift({32'd0, grav}, pg_s2);
			mam_s3   <= sgpf_pkg::norm_shift({16'd0, ma_s2}, pma_s2);
			mbm_s3   <= sgpf_pkg::norm_shift({16'd0, mb_s2}, pmb_s2);
			bex_s3   <= sgpf_pkg::pos_exp(pg_s2) + sgpf_pkg::pos_exp(pma_s2)
				+ sgpf_pkg::pos_exp(pmb_s2);
			neg_s3   <= neg_s2;
			mzero_s3 <= mzero_s2;
			zfac_s3  <= zfac_s2;

			// s4: squared distance, g times mass_a
			d2_s4    <= sa_s3 + sb_s3;
			p1_s4    <= 64'(gm_s3) * 64'(mam_s3);
			mbm_s4   <= mbm_s3;
			bex_s4   <= bex_s3;
			magm_s4  <= magm_s3;
			magx_s4  <= magx_s3;
			neg_s4   <= neg_s3;
			mzero_s4 <= mzero_s3;
			zfac_s4  <= zfac_s3;

			// s5: top bit of d2, renormalize first product
			pd_s5    <= sgpf_pkg::lead64(d2_s4);
			zden_s5  <= (d2_s4 == 64'd0);
			d2_s5    <= d2_s4;
			m1_s5    <= sgpf_pkg::renorm_mant(p1_s4);
			bex_s5   <= bex_s4 + sgpf_pkg::renorm_exp(p1_s4);
			mbm_s5   <= mbm_s4;
			magm_s5  <= magm_s4;
			magx_s5  <= magx_s4;
			neg_s5   <= neg_s4;
			mzero_s5 <= mzero_s4;
			zfac_s5  <= zfac_s4;

			// s6: q2.30 mantissa of d2 at an even exponent, times mass_b
			m_s6     <= sgpf_pkg::norm_shift(d2_s5, {pd_s5[5:1], 1'b1});
			k3_s6    <= 8'(3 * (int'(pd_s5[5:1]) - sgpf_pkg::FRAC_BITS));
			p2_s6    <= 64'(m1_s5) * 64'(mbm_s5);
			zden_s6  <= zden_s5;
			bex_s6   <= bex_s5;
			magm_s6  <= magm_s5;
			magx_s6  <= magx_s5;
			neg_s6   <= neg_s5;
			mzero_s6 <= mzero_s5;
			zfac_s6  <= zfac_s5;

			// s7: newton seed and side data
			y_s7          <= sgpf_pkg::SEED_Q30 - {2'b00, m_s6[31:2]};
			m_s7          <= m_s6;
			side_s7.neg   <= neg_s6;
			side_s7.mzero <= mzero_s6;
			side_s7.magm  <= magm_s6;
			side_s7.magx  <= magx_s6;
			side_s7.basem <= sgpf_pkg::renorm_mant(p2_s6);
			side_s7.bex   <= bex_s6 + sgpf_pkg::renorm_exp(p2_s6);
			side_s7.k3    <= k3_s6;
			side_s7.zden  <= zden_s6;
			side_s7.zfac  <= zfac_s6;
		end
	end

	assign valid = v_s7;
	assign m     = m_s7;
	assign seed  = y_s7;
	assign side  = side_s7;

endmodule

>>> rtl/core/sgpf_rsqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgpf_rsqrt
// unrolled newton reciprocal square root in q2.30, three stages per step,
// then two stages for the cube
// ----------------------------------------------------------------------------
module sgpf_rsqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             seed_valid,
	input  logic [31:0]      m,
	input  logic [31:0]      seed,
	input  sgpf_pkg::side_t  seed_side,
	output logic             valid,
	output logic [33:0]      y3,
	output sgpf_pkg::side_t  side
);

	logic [sgpf_pkg::NEWTON_STEPS:0] v_b;
	logic [31:0]     y_b    [sgpf_pkg::NEWTON_STEPS+1];
	logic [31:0]     m_b    [sgpf_pkg::NEWTON_STEPS+1];
	sgpf_pkg::side_t side_b [sgpf_pkg::NEWTON_STEPS+1];

	logic            v_f1, v_f2;
	logic [31:0]     y_f1, y2_f1;
	logic [33:0]     y3_f2;
	sgpf_pkg::side_t side_f1, side_f2;
	logic [63:0]     yy_f, yyy_f;

	assign v_b[0]    = seed_valid;
	assign y_b[0]    = seed;
	assign m_b[0]    = m;
	assign side_b[0] = seed_side;

	for (genvar g = 0; g < sgpf_pkg::NEWTON_STEPS; g++) begin : g_step
		logic            v_s1, v_s2, v_s3;
		logic [31:0]     y_s1, y2_s1, m_s1, y_s2, h_s2, m_s2, y_s3, m_s3;
		sgpf_pkg::side_t side_s1, side_s2, side_s3;
		logic [63:0]     yy, my, yh;
		logic [33:0]     t, hsub;
		logic [31:0]     h;

		// y*y, m*y^2, then y*(3 - m*y^2)/2 with the bracket clamped at zero
		assign yy   = 64'(y_b[g]) * 64'(y_b[g]);
		assign my   = 64'(m_s1) * 64'(y2_s1);
		assign t    = my[63:30];
		assign hsub = sgpf_pkg::THREE_Q30 - t;
		assign h    = (t >= sgpf_pkg::THREE_Q30) ? 32'd0 : hsub[31:0];
		assign yh   = 64'(y_s2) * 64'(h_s2);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1 <= 1'b0;
				v_s2 <= 1'b0;
				v_s3 <= 1'b0;
			end else if (adv) begin
				v_s1 <= v_b[g];
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				y_s1    <= y_b[g];
				y2_s1   <= yy[61:30];
				m_s1    <= m_b[g];
				side_s1 <= side_b[g];
				y_s2    <= y_s1;
				h_s2    <= h;
				m_s2    <= m_s1;
				side_s2 <= side_s1;
				y_s3    <= yh[62:31];
				m_s3    <= m_s2;
				side_s3 <= side_s2;
			end
		end

		assign v_b[g+1]    = v_s3;
		assign y_b[g+1]    = y_s3;
		assign m_b[g+1]    = m_s3;
		assign side_b[g+1] = side_s3;
	end

	// cube of the reciprocal square root
	assign yy_f  = 64'(y_b[sgpf_pkg::NEWTON_STEPS]) * 64'(y_b[sgpf_pkg::NEWTON_STEPS]);
	assign yyy_f = 64'(y2_f1) * 64'(y_f1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1 <= 1'b0;
			v_f2 <= 1'b0;
		end else if (adv) begin
			v_f1 <= v_b[sgpf_pkg::NEWTON_STEPS];
			v_f2 <= v_f1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_f1    <= y_b[sgpf_pkg::NEWTON_STEPS];
			y2_f1   <= yy_f[61:30];
			side_f1 <= side_b[sgpf_pkg::NEWTON_STEPS];
			y3_f2   <= yyy_f[63:30];
			side_f2 <= side_f1;
		end
	end

	assign valid = v_f2;
	assign y3    = y3_f2;
	assign side  = side_f2;

endmodule

>>> rtl/core/sgpf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgpf_back
// mantissa chain through y^3 and each displacement component, final
// scaling shift, saturation and sign; eight stages
// ----------------------------------------------------------------------------
module sgpf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             cube_valid,
	input  logic [33:0]      y3,
	input  sgpf_pkg::side_t  cube_side,
	output logic             valid,
	output sgpf_pkg::force_t res
);

	localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MAG = 64'h8000_0000_0000_0000;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	logic [33:0]     y3_s1;
	logic [5:0]      py_s1;
	logic            zy_s1;
	sgpf_pkg::side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	sgpf_pkg::side_t side_c;
	logic [31:0]     y3m_s2, bm_s4;
	logic signed [sgpf_pkg::EXW-1:0] ex_s2, ex_s3, ex_s4, ex_s5;
	logic [63:0]     pb_s3;
	logic [2:0][63:0] pc_s5;
	logic [2:0][31:0] mant_s6;
	logic [2:0][sgpf_pkg::EXW-1:0] sh_s6;
	logic [2:0][63:0] val_s7;
	logic [2:0]      over_s7;
	sgpf_pkg::force_t res_s8;

	logic [2:0][63:0] val_c;
	logic [2:0]       over_c;
	logic [2:0][63:0] frc_c;
	logic [2:0]       sat_c;

	// zero cube is folded into the zero factor case
	always_comb begin
		side_c      = side_s1;
		side_c.zfac = side_s1.zfac | zy_s1;
	end

	// scaling shift per component
	always_comb begin
		logic signed [sgpf_pkg::EXW-1:0] sh;
		logic [sgpf_pkg::EXW-1:0] nsh;
		for (int c = 0; c < 3; c++) begin
			sh  = $signed(sh_s6[c]);
			nsh = -sh_s6[c];
			over_c[c] = 1'b0;
			if (sh > $signed(sgpf_pkg::EXW'(32))) begin
				over_c[c] = 1'b1;
				val_c[c]  = 64'd0;
			end else if (sh >= $signed(sgpf_pkg::EXW'(0))) begin
				val_c[c] = 64'(mant_s6[c]) << sh_s6[c][5:0];
			end else if (sh <= sgpf_pkg::EXW'(-64)) begin
				val_c[c] = 64'd0;
			end else begin
				val_c[c] = 64'(mant_s6[c]) >> nsh[5:0];
			end
		end
	end

	// saturate and apply the opposite sign
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sat_c[c] = 1'b0;
			if (side_s7.zden || side_s7.zfac || side_s7.mzero[c]) begin
				frc_c[c] = 64'd0;
			end else if (!side_s7.neg[c]) begin
				if (over_s7[c] || (val_s7[c] > NEG_MAG)) begin
					sat_c[c] = 1'b1;
					frc_c[c] = NEG_MAG;
				end else begin
					frc_c[c] = 64'd0 - val_s7[c];
				end
			end else begin
				if (over_s7[c] || (val_s7[c] > POS_MAX)) begin
					sat_c[c] = 1'b1;
					frc_c[c] = POS_MAX;
				end else begin
					frc_c[c] = val_s7[c];
				end
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cube_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: top bit of the cube
			y3_s1   <= y3;
			py_s1   <= sgpf_pkg::lead64({30'd0, y3});
			zy_s1   <= (y3 == 34'd0);
			side_s1 <= cube_side;

			// s2: normalize the cube
			y3m_s2  <= sgpf_pkg::norm_shift({30'd0, y3_s1}, py_s1);
			ex_s2   <= side_s1.bex + sgpf_pkg::pos_exp(py_s1);
			side_s2 <= side_c;

			// s3: mass product times cube
			pb_s3   <= 64'(side_s2.basem) * 64'(y3m_s2);
			ex_s3   <= ex_s2;
			side_s3 <= side_s2;

			// s4: renormalize
			bm_s4   <= sgpf_pkg::renorm_mant(pb_s3);
			ex_s4   <= ex_s3 + sgpf_pkg::renorm_exp(pb_s3);
			side_s4 <= side_s3;

			// s5: times each displacement magnitude
			for (int c = 0; c < 3; c++) begin
				pc_s5[c] <= 64'(bm_s4) * 64'(side_s4.magm[c]);
			end
			ex_s5   <= ex_s4;
			side_s5 <= side_s4;

			// s6: renormalize and form the scaling shift
			for (int c = 0; c < 3; c++) begin
				mant_s6[c] <= sgpf_pkg::renorm_mant(pc_s5[c]);
				sh_s6[c]   <= ex_s5 + $signed(side_s5.magx[c])
					+ sgpf_pkg::renorm_exp(pc_s5[c])
					- $signed(sgpf_pkg::EXW'(sgpf_pkg::SH_BIAS)) - side_s5.k3;
			end
			side_s6 <= side_s5;

			// s7: shift
			val_s7  <= val_c;
			over_s7 <= over_c;
			side_s7 <= side_s6;

			// s8: result
			res_s8.force_x       <= frc_c[0];
			res_s8.force_y       <= frc_c[1];
			res_s8.force_z       <= frc_c[2];
			res_s8.overflow_flag <= side_s7.zden
				| (!side_s7.zfac & (|sat_c));
		end
	end

	assign valid = v_s8;
	assign res   = res_s8;

endmodule

>>> rtl/core/softened_gravity_pair_force_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softened_gravity_pair_force_unit
// plummer softened gravitational pair force, fixed point, fully pipelined
//
//   channel  signals                               direction  transfer when
//   pair     pair_valid, pair_stall, pair          in         valid & !stall
//   result   result_valid, result_stall, result    out        valid & !stall
//   cfg      cfg_valid, cfg_ready, cfg_index, data in         valid & ready
//
// one pair per cycle while the skid register is empty; 7 front stages, 3 per
// newton step over 6 steps plus 2 for the cube and 8 back stages, a depth set
// by the chain of dependent multiplies in the reciprocal square root.
// reset clears valid bits and the configuration registers to their defaults.
// a stalled result moves into a skid register as the pipeline steps on;
// the pipeline holds while the skid register is full.
// ----------------------------------------------------------------------------
module softened_gravity_pair_force_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pair_valid,
	output logic                pair_stall,
	input  sgpf_pkg::pair_t     pair,
	output logic                result_valid,
	input  logic                result_stall,
	output sgpf_pkg::force_t    result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  sgpf_pkg::cfg_idx_t  cfg_index,
	input  logic [31:0]         cfg_data
);

	logic [31:0]      grav_q, soft_q;
	logic             skid_v_q;
	sgpf_pkg::force_t skid_q;
	logic             adv;

	logic             f_valid;
	logic [31:0]      f_m, f_seed;
	sgpf_pkg::side_t  f_side;
	logic             r_valid;
	logic [33:0]      r_y3;
	sgpf_pkg::side_t  r_side;
	logic             b_valid;
	sgpf_pkg::force_t b_res;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= sgpf_pkg::GRAV_RESET;
			soft_q <= sgpf_pkg::SOFT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				sgpf_pkg::CFG_GRAV: grav_q <= cfg_data;
				sgpf_pkg::CFG_SOFT: soft_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline steps unless the skid register is occupied
	assign adv        = !skid_v_q;
	assign pair_stall = skid_v_q;

	sgpf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (pair_valid),
		.pair     (pair),
		.grav     (grav_q),
		.eps_sq   (soft_q),
		.valid    (f_valid),
		.m        (f_m),
		.seed     (f_seed),
		.side     (f_side)
	);

	sgpf_rsqrt u_rsqrt (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.seed_valid (f_valid),
		.m          (f_m),
		.seed       (f_seed),
		.seed_side  (f_side),
		.valid      (r_valid),
		.y3         (r_y3),
		.side       (r_side)
	);

	sgpf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.cube_valid (r_valid),
		.y3         (r_y3),
		.cube_side  (r_side),
		.valid      (b_valid),
		.res        (b_res)
	);

	// skid register on the result side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (!result_stall) skid_v_q <= 1'b0;
		end else if (b_valid && result_stall) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q && b_valid && result_stall) skid_q <= b_res;
	end

	assign result_valid = skid_v_q | b_valid;
	assign result       = skid_v_q ? skid_q : b_res;

endmodule

>>> test/sgpf_force_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgpf_force_checker
// watches the pair, result and cfg channels of the softened gravity pair
// force unit, computes the expected force of every accepted pair with its own
// fixed point arithmetic, and compares each result field by field in order
// ----------------------------------------------------------------------------
module sgpf_force_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pair_valid,
	input  logic                pair_stall,
	input  sgpf_pkg::pair_t     pair,
	input  logic                result_valid,
	input  logic                result_stall,
	input  sgpf_pkg::force_t    result,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  sgpf_pkg::cfg_idx_t  cfg_index,
	input  logic [31:0]         cfg_data,
	output int                  errors,
	output int                  pending,
	output int                  checked
);

	localparam int FB = sgpf_pkg::FRAC_BITS;

	logic [31:0] grav_q;
	logic [31:0] soft_q;
	sgpf_pkg::force_t expected_forces[$];

	assign pending = expected_forces.size();

	// index of the highest set bit
	function automatic int msb_pos(input logic [63:0] v);
		int p;
		p = 0;
		for (int i = 0; i < 64; i++)
			if (v[i]) p = i;
		return p;
	endfunction

	// scale to a mantissa with bit 31 set, tracking the exponent
	function automatic logic [63:0] to_mant(input logic [63:0] v, inout int ex);
		int p;
		p = msb_pos(v);
		if (p >= 31) begin
			ex += p - 31;
			return v >> (p - 31);
		end
		ex -= 31 - p;
		return v << (31 - p);
	endfunction

	function automatic logic [63:0] inv_sqrt_q30(input logic [63:0] m);
		logic [63:0] y, y2, t, h;
		y = (64'd3 << 29) - (m >> 2);
		for (int i = 0; i < sgpf_pkg::NEWTON_STEPS; i++) begin
			y2 = (y * y) >> 30;
			t = (m * y2) >> 30;
			h = (t >= 64'd3 << 30) ? 64'd0 : ((64'd3 << 30) - t);
			y = (y * h) >> 31;
		end
		return y;
	endfunction

	function automatic sgpf_pkg::force_t pair_force(input sgpf_pkg::pair_t p);
		sgpf_pkg::force_t f;
		logic [63:0] mag[3];
		logic neg[3];
		logic [31:0] raw[3];
		logic [63:0] d2, m, y, y3, base, mant, val, fm;
		int e, k3, ebase, ex, sh;
		logic over;
		f = '0;
		raw[0] = p.disp_x;
		raw[1] = p.disp_y;
		raw[2] = p.disp_z;
		for (int c = 0; c < 3; c++) begin
			neg[c] = raw[c][31];
			mag[c] = neg[c] ? (64'h1_0000_0000 - {32'd0, raw[c]}) : {32'd0, raw[c]};
		end
		d2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2] + ({32'd0, soft_q} << FB);
		if (d2 == 0) begin
			f.overflow_flag = 1'b1;
			return f;
		end
		if (grav_q == 0 || p.mass_a == 0 || p.mass_b == 0) return f;
		e = msb_pos(d2) & ~1;
		m = (e >= 30) ? (d2 >> (e - 30)) : (d2 << (30 - e));
		k3 = 3 * ((e - 2 * FB) / 2);
		y = inv_sqrt_q30(m);
		y3 = (((y * y) >> 30) * y) >> 30;
		if (y3 == 0) return f;
		ebase = 0;
		base = to_mant({32'd0, grav_q}, ebase);
		fm = to_mant({16'd0, p.mass_a}, ebase);
		base = to_mant(base * fm, ebase);
		fm = to_mant({16'd0, p.mass_b}, ebase);
		base = to_mant(base * fm, ebase);
		fm = to_mant(y3, ebase);
		base = to_mant(base * fm, ebase);
		for (int c = 0; c < 3; c++) begin
			logic [63:0] out_c;
			out_c = '0;
			over = 1'b0;
			if (mag[c] != 0) begin
				ex = ebase;
				fm = to_mant(mag[c], ex);
				mant = to_mant(base * fm, ex);
				sh = ex - 3 * FB - 30 - k3;
				if (sh > 32) begin
					over = 1'b1;
					val = 0;
				end else if (sh >= 0) val = mant << sh;
				else if (sh <= -64) val = 0;
				else val = mant >> (-sh);
				if (!neg[c]) begin
					if (over || val > 64'h8000_0000_0000_0000) begin
						over = 1'b1;
						val = 64'h8000_0000_0000_0000;
					end
					out_c = 64'd0 - val;
				end else begin
					if (over || val > 64'h7FFF_FFFF_FFFF_FFFF) begin
						over = 1'b1;
						val = 64'h7FFF_FFFF_FFFF_FFFF;
					end
					out_c = val;
				end
				if (over) f.overflow_flag = 1'b1;
			end
			case (c)
				0: f.force_x = out_c;
				1: f.force_y = out_c;
				default: f.force_z = out_c;
			endcase
		end
		return f;
	endfunction

	// follow the channels at every edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= sgpf_pkg::GRAV_RESET;
			soft_q <= sgpf_pkg::SOFT_RESET;
			errors <= 0;
			checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == sgpf_pkg::CFG_GRAV) grav_q <= cfg_data;
				else soft_q <= cfg_data;
			end
			if (pair_valid && !pair_stall)
				expected_forces.insert(expected_forces.size(), pair_force(pair));
			if (result_valid && !result_stall) begin
				if (expected_forces.size() == 0) begin
					$display("%0t: unexpected result %h", $time, result);
					errors <= errors + 1;
				end else begin
					sgpf_pkg::force_t w;
					w = expected_forces.pop_front();
					checked <= checked + 1;
					if (w.force_x !== result.force_x) begin
						$display("%0t: force_x expected %h actual %h", $time, w.force_x,
							result.force_x);
						errors <= errors + 1;
					end else if (w.force_y !== result.force_y) begin
						$display("%0t: force_y expected %h actual %h", $time, w.force_y,
							result.force_y);
						errors <= errors + 1;
					end else if (w.force_z !== result.force_z) begin
						$display("%0t: force_z expected %h actual %h", $time, w.force_z,
							result.force_z);
						errors <= errors + 1;
					end else if (w.overflow_flag !== result.overflow_flag) begin
						$display("%0t: overflow_flag expected %b actual %b", $time,
							w.overflow_flag, result.overflow_flag);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

>>> test/tb_softened_gravity_pair_force_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_softened_gravity_pair_force_unit
// drives directed and random particle pairs through the force unit under
// several gravity and softening settings with random idle on both channels;
// a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_softened_gravity_pair_force_unit;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                pair_valid = 1'b0;
	logic                pair_stall;
	sgpf_pkg::pair_t     pair = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	sgpf_pkg::force_t    result;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	sgpf_pkg::cfg_idx_t  cfg_index = sgpf_pkg::CFG_GRAV;
	logic [31:0]         cfg_data = '0;
	int                  errors, pending, checked;
	int                  send_idle = 0;
	int                  recv_idle = 0;
	int                  sent = 0;

	always #10 clk = ~clk;

	softened_gravity_pair_force_unit DUT (.*);

	sgpf_force_checker u_checker (.*);

	// receiver stall
	always @(posedge clk) result_stall <= ($urandom_range(99) < recv_idle);

	// displacement with a varied magnitude range
	function automatic logic [31:0] rand_disp();
		case ($urandom_range(5))
			0: return 32'($signed($urandom_range(0, 200)) - 100);
			1: return 32'($signed($urandom_range(0, 131072)) - 65536);
			2: return ($urandom & 32'h00FF_FFFF) ^ ({32{1'($urandom_range(1))}});
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [47:0] rand_mass();
		case ($urandom_range(4))
			0: return 48'($urandom_range(0, 3));
			1: return {16'd0, $urandom};
			2: return 48'h0001_0000;
			default: return 48'({$urandom, $urandom});
		endcase
	endfunction

	// one pair transfer, valid stays high until the next idle or the end
	task automatic send_pair(input logic [31:0] x, y, z, input logic [47:0] a, b);
		while ($urandom_range(99) < send_idle) begin
			pair_valid <= 1'b0;
			@(posedge clk);
		end
		pair_valid <= 1'b1;
		pair <= '{x, y, z, a, b};
		@(posedge clk);
		while (pair_stall) @(posedge clk);
		sent++;
	endtask

	// write one register once the pipe is empty
	task automatic write_reg(input sgpf_pkg::cfg_idx_t idx, input logic [31:0] v);
		pair_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_pairs(input int n);
		for (int i = 0; i < n; i++)
			send_pair(rand_disp(), rand_disp(), rand_disp(), rand_mass(), rand_mass());
	endtask

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, zero factors, zero denominator
		send_pair(0, 0, 0, 48'h1_0000, 48'h1_0000);
		send_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
			48'hFFFF_FFFF_FFFF);
		send_pair(32'h0001_0000, 0, 32'hFFFF_0000, 48'h1_0000, 0);
		send_pair(32'h0001_0000, 32'hFFFF_0000, 0, 0, 48'h1_0000);
		send_pair(1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 1);
		send_pair(32'h0000_0100, 32'h0000_0100, 32'h0000_0100, 48'hFFFF_FFFF_FFFF,
			48'hFFFF_FFFF_FFFF);
		write_reg(sgpf_pkg::CFG_SOFT, 32'd0);
		send_pair(0, 0, 0, 48'h1_0000, 48'h1_0000);
		send_pair(1, 0, 0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		send_pair(32'h8000_0000, 0, 0, 1, 1);
		write_reg(sgpf_pkg::CFG_GRAV, 32'd0);
		send_pair(32'h0001_0000, 1, 1, 48'h1_0000, 48'h1_0000);
		send_pair(0, 0, 0, 48'h1_0000, 48'h1_0000);
		write_reg(sgpf_pkg::CFG_GRAV, 32'hFFFF_FFFF);
		write_reg(sgpf_pkg::CFG_SOFT, 32'hFFFF_FFFF);
		send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 48'hFFFF_FFFF_FFFF,
			48'hFFFF_FFFF_FFFF);
		send_pair(0, 0, 0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		// random phases with differing idle and settings
		send_idle = 17;
		recv_idle = 51;
		write_reg(sgpf_pkg::CFG_GRAV, sgpf_pkg::GRAV_RESET);
		write_reg(sgpf_pkg::CFG_SOFT, sgpf_pkg::SOFT_RESET);
		random_pairs(200);
		send_idle = 51;
		recv_idle = 17;
		write_reg(sgpf_pkg::CFG_GRAV, $urandom);
		write_reg(sgpf_pkg::CFG_SOFT, $urandom_range(0, 65535));
		random_pairs(200);
		send_idle = 0;
		recv_idle = 0;
		write_reg(sgpf_pkg::CFG_GRAV, 32'd1);
		write_reg(sgpf_pkg::CFG_SOFT, 32'd1);
		random_pairs(200);
		pair_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("sent %0d pairs, checked %0d results over seven register settings",
			sent, checked);
		if (errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

>>> sim.f
rtl/core/sgpf_pkg.sv
rtl/core/sgpf_front.sv
rtl/core/sgpf_rsqrt.sv
rtl/core/sgpf_back.sv
rtl/core/softened_gravity_pair_force_unit.sv
test/sgpf_force_checker.sv
test/tb_softened_gravity_pair_force_unit.sv
